// ===== rtl/pasr_pkg.sv =====
// Shared types and constants for the packed array swap-remove block.
// No dependencies; imported by pasr_ram and packed_array_swap_remove_core.
`timescale 1ns / 1ps

package pasr_pkg;

    localparam int DEPTH_DEF        = 1024;
    localparam int ELEMENT_BITS_DEF = 64;

    localparam int IDX_W  = 10;   // slot_index / result_index
    localparam int CNT_W  = 11;   // capacity / live count
    localparam int DATA_W = 64;   // write_data / read_data

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOINIT  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADIDX  = 3'd4
    } status_t;

endpackage

// ===== rtl/pasr_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Uses pasr_pkg for default sizes.
`timescale 1ns / 1ps

module pasr_ram
    import pasr_pkg::*;
#(
    parameter int WIDTH = ELEMENT_BITS_DEF,
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/packed_array_swap_remove_core.sv =====
// Top level: packed element store with swap-and-pop removal.
// Depends on pasr_pkg and pasr_ram.
//
//  channel  | direction | contents
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | request word: mode, slot_index, write_data
//  m_*      | out       | result word: status, result_index, moved,
//           |           |   read_data, live_elements
//  cfg_*    | in        | capacity register write (clears the live count)
//
// Each request passes through accept (checks and memory access), then
// completion (read data returns, free writes the moved element into the hole).
// With a single memory port, free reads the last slot on accept, then writes it.
// The result register lets the next request be taken while a result waits;
// completion stalls only while that register is still full.
// Reset (aresetn low, synchronous) clears the count and capacity; element
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module packed_array_swap_remove_core
    import pasr_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [9:0] slot_index, [73:10] write_data, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [9:0] result_index, [73:10] read_data,
                                   // [84:74] live_elements, rest zero
    output logic [3:0]  m_tuser,   // [2:0] status, [3] moved

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // capacity
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic {S_IDLE, S_EXEC} fsm_t;

    fsm_t                    state_reg;
    logic [CNT_W-1:0]        live_reg;
    logic [CNT_W-1:0]        cap_reg;

    // request context kept for the completion cycle
    status_t                 ctx_status_reg;
    logic [IDX_W-1:0]        ctx_idx_reg;
    logic                    ctx_moved_reg;
    logic                    ctx_read_reg;
    logic [AW-1:0]           hole_reg;

    logic                    m_valid_reg;
    status_t                 m_status_reg;
    logic [IDX_W-1:0]        m_idx_reg;
    logic                    m_moved_reg;
    logic [DATA_W-1:0]       m_data_reg;
    logic [CNT_W-1:0]        m_live_reg;

    mode_t                   in_mode;
    logic [IDX_W-1:0]        in_idx;
    logic [ELEMENT_BITS-1:0] in_wdata;
    logic [AW-1:0]           in_addr;
    logic [AW+IDX_W-1:0]     in_addr_wide;
    logic [CNT_W-1:0]        last_cnt;
    logic [AW+CNT_W-1:0]     last_wide;
    logic [AW-1:0]           last_addr;

    status_t                 dec_status;
    logic [IDX_W-1:0]        dec_idx;
    logic                    dec_moved;
    logic                    dec_read;
    logic                    dec_write;
    logic [CNT_W-1:0]        live_next;

    logic                    accept;
    logic                    out_free;
    logic                    finish;

    logic                    ram_en;
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [ELEMENT_BITS-1:0] ram_wdata;
    logic [ELEMENT_BITS-1:0] ram_rdata;
    logic [CNT_W-1:0]        cap_next;

    assign in_mode      = mode_t'(s_tuser);
    assign in_idx       = s_tdata[IDX_W-1:0];
    assign in_wdata     = s_tdata[IDX_W +: ELEMENT_BITS];
    assign in_addr_wide = {{AW{1'b0}}, in_idx};
    assign in_addr      = in_addr_wide[AW-1:0];
    assign last_cnt     = live_reg - 1'b1;
    assign last_wide    = {{AW{1'b0}}, last_cnt};
    assign last_addr    = last_wide[AW-1:0];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign finish    = (state_reg == S_EXEC) && out_free;

    // effective capacity saturates at DEPTH
    assign cap_next = (32'(cfg_data) > 32'(DEPTH)) ? CNT_W'(DEPTH) : cfg_data;

    always_comb begin
        dec_status = ST_OK;
        dec_idx    = '0;
        dec_moved  = 1'b0;
        dec_read   = 1'b0;
        dec_write  = 1'b0;
        live_next  = live_reg;
        if (cap_reg == '0) begin
            dec_status = ST_NOINIT;
        end else begin
            unique case (in_mode)
                MODE_ALLOC: begin
                    if (live_reg >= cap_reg) begin
                        dec_status = ST_FULL;
                    end else begin
                        dec_idx   = live_reg[IDX_W-1:0];
                        live_next = live_reg + 1'b1;
                    end
                end
                MODE_FREE: begin
                    if (live_reg == '0) begin
                        dec_status = ST_EMPTY;
                    end else if ({1'b0, in_idx} >= live_reg) begin
                        dec_status = ST_BADIDX;
                    end else begin
                        dec_idx   = in_idx;
                        dec_moved = ({1'b0, in_idx} != last_cnt);
                        live_next = last_cnt;
                    end
                end
                MODE_READ, MODE_WRITE: begin
                    if ({1'b0, in_idx} >= live_reg) begin
                        dec_status = ST_BADIDX;
                    end else if (in_mode == MODE_READ) begin
                        dec_read = 1'b1;
                    end else begin
                        dec_write = 1'b1;
                    end
                end
                default: dec_status = ST_OK;
            endcase
        end
    end

    // one port: requests use it on accept, a move writes back on completion
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = in_addr;
        ram_wdata = in_wdata;
        if (accept) begin
            ram_en   = dec_read || dec_write || dec_moved;
            ram_we   = dec_write;
            ram_addr = dec_moved ? last_addr : in_addr;
        end else if (finish && ctx_moved_reg) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = hole_reg;
            ram_wdata = ram_rdata;
        end
    end

    pasr_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            live_reg    <= '0;
            cap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg  <= cap_next;
                live_reg <= '0;
            end else if (accept) begin
                live_reg <= live_next;
            end

            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        ctx_status_reg <= dec_status;
                        ctx_idx_reg    <= dec_idx;
                        ctx_moved_reg  <= dec_moved;
                        ctx_read_reg   <= dec_read;
                        hole_reg       <= in_addr;
                        state_reg      <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_status_reg <= ctx_status_reg;
                        m_idx_reg    <= ctx_idx_reg;
                        m_moved_reg  <= ctx_moved_reg;
                        m_data_reg   <= ctx_read_reg ? DATA_W'(ram_rdata) : '0;
                        m_live_reg   <= live_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_live_reg, m_data_reg, m_idx_reg};
    assign m_tuser  = {m_moved_reg, m_status_reg};

endmodule
